[rtl/ptcta_pkg.sv]
package ptcta_pkg;

    localparam int unsigned ID_W     = 12;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned ID_SPACE = 1 << ID_W;

    localparam logic FUNC_SWITCH = 1'b0;
    localparam logic FUNC_EXIT   = 1'b1;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic delta;
        logic sum;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

[rtl/ptcta_ctrl.sv]
module ptcta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptcta_pkg::t_status i_status,
    output ptcta_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DELTA = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_DELTA;
            end
            ST_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

`ifndef SYNTH
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == ST_READ)
        else $error("accepted transaction did not start a table read");

    a_done_waits_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && !i_status.out_free |=> r_state == ST_DONE)
        else $error("result dropped while output register busy");
`endif

endmodule

[rtl/ptcta_dpath.sv]
module ptcta_dpath #(
    parameter int TASK_IDS = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptcta_pkg::t_cmd                      i_cmd,
    output ptcta_pkg::t_status                   o_status,
    input  logic                                 i_func,
    input  logic [ptcta_pkg::TIME_W-1:0]         i_time_ns,
    input  logic [ptcta_pkg::ID_W-1:0]           i_prev_task,
    input  logic [ptcta_pkg::ID_W-1:0]           i_next_task,
    input  logic [ptcta_pkg::ID_W-1:0]           i_exit_task,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ptcta_pkg::ID_W-1:0]           o_total_task,
    output logic [ptcta_pkg::TIME_W-1:0]         o_total_ns,
    output logic                                 o_total_present
);

    localparam int DEPTH = (TASK_IDS < int'(ptcta_pkg::ID_SPACE)) ?
                           TASK_IDS : int'(ptcta_pkg::ID_SPACE);
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = ptcta_pkg::TIME_W + 1;

    function automatic logic in_table(input logic [ptcta_pkg::ID_W-1:0] id);
        return 32'(id) < 32'(TASK_IDS);
    endfunction

    // entry layout: {valid, value}
    logic [EW-1:0] r_mem_a [DEPTH];
    logic [EW-1:0] r_mem_b [DEPTH];
    logic [EW-1:0] r_rd_a;
    logic [EW-1:0] r_rd_b;

    logic [AW-1:0]                   r_clr_addr;
    logic                            r_func;
    logic [ptcta_pkg::TIME_W-1:0]    r_time;
    logic [ptcta_pkg::ID_W-1:0]      r_id;
    logic [ptcta_pkg::ID_W-1:0]      r_next;
    logic                            r_id_ok;
    logic                            r_next_ok;
    logic [ptcta_pkg::TIME_W-1:0]    r_delta;
    logic [ptcta_pkg::TIME_W-1:0]    r_tot;
    logic                            r_sv;
    logic                            r_tv;

    logic                            r_out_valid;
    logic [ptcta_pkg::ID_W-1:0]      r_out_task;
    logic [ptcta_pkg::TIME_W-1:0]    r_out_ns;
    logic                            r_out_present;

    logic [ptcta_pkg::ID_W-1:0]      load_id;
    logic                            a_we;
    logic                            b_we;
    logic [AW-1:0]                   a_waddr;
    logic [AW-1:0]                   b_waddr;
    logic [EW-1:0]                   a_wdata;
    logic [EW-1:0]                   b_wdata;
    logic                            is_exit;

    assign load_id = (i_func == ptcta_pkg::FUNC_EXIT) ? i_exit_task : i_prev_task;
    assign is_exit = (r_func == ptcta_pkg::FUNC_EXIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_time    <= i_time_ns;
            r_id      <= load_id;
            r_next    <= i_next_task;
            r_id_ok   <= in_table(load_id) &&
                         ((i_func == ptcta_pkg::FUNC_EXIT) || (load_id != '0));
            r_next_ok <= in_table(i_next_task) && (i_next_task != '0);
        end
        if (i_cmd.delta) begin
            r_delta <= r_time - r_rd_a[ptcta_pkg::TIME_W-1:0];
            r_sv    <= r_id_ok && r_rd_a[EW-1] && !is_exit;
            r_tv    <= r_id_ok && r_rd_b[EW-1];
            r_tot   <= r_rd_b[ptcta_pkg::TIME_W-1:0];
        end
        if (i_cmd.sum && r_sv) begin
            r_tot <= r_tv ? (r_tot + r_delta) : r_delta;
            r_tv  <= 1'b1;
        end
    end

    always_comb begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = r_clr_addr;
        b_waddr = r_clr_addr;
        a_wdata = '0;
        b_wdata = '0;
        if (i_cmd.clr) begin
            a_we = 1'b1;
            b_we = 1'b1;
        end else if (i_cmd.done) begin
            b_waddr = r_id[AW-1:0];
            if (is_exit) begin
                a_we    = r_id_ok;
                b_we    = r_id_ok;
                a_waddr = r_id[AW-1:0];
            end else begin
                a_we    = r_next_ok;
                a_waddr = r_next[AW-1:0];
                a_wdata = {1'b1, r_time};
                b_we    = r_id_ok && r_sv;
                b_wdata = {r_tv, r_tot};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_mem_a[a_waddr] <= a_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem_a[r_id[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem_b[b_waddr] <= b_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_b <= r_mem_b[r_id[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out_task    <= r_id;
            r_out_ns      <= r_tv ? r_tot : '0;
            r_out_present <= r_tv;
        end
    end

    assign o_status.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_total_task    = r_out_task;
    assign o_total_ns      = r_out_ns;
    assign o_total_present = r_out_present;

`ifndef SYNTH
    a_done_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending transaction");

    a_accounted_is_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done && r_sv |=> o_out_valid && o_total_present)
        else $error("accounted task reported without a total");
`endif

endmodule

[rtl/per_task_cpu_time_accounting_unit.sv]
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_func i_time_ns i_prev_task
//         |           |                            | i_next_task i_exit_task
// out     | output    | o_out_valid / i_out_ready  | o_total_task o_total_ns
//         |           |                            | o_total_present
//
// a transaction steps through accept, table read, delta subtract, total add and write back
// the two 65-bit table memories (start, total) allow one read-modify-write per transaction
// after reset a clearing pass over all min(TASK_IDS, 4096) table entries runs before the first accept
// a result waits in the output register; the next transaction is accepted meanwhile
// and stalls in write back only if the output register is still full
module per_task_cpu_time_accounting_unit #(
    parameter int TASK_IDS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [ptcta_pkg::TIME_W-1:0]  i_time_ns,
    input  logic [ptcta_pkg::ID_W-1:0]    i_prev_task,
    input  logic [ptcta_pkg::ID_W-1:0]    i_next_task,
    input  logic [ptcta_pkg::ID_W-1:0]    i_exit_task,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptcta_pkg::ID_W-1:0]    o_total_task,
    output logic [ptcta_pkg::TIME_W-1:0]  o_total_ns,
    output logic                          o_total_present
);

    ptcta_pkg::t_cmd    cmd;
    ptcta_pkg::t_status status;

    ptcta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ptcta_dpath #(
        .TASK_IDS (TASK_IDS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_func          (i_func),
        .i_time_ns       (i_time_ns),
        .i_prev_task     (i_prev_task),
        .i_next_task     (i_next_task),
        .i_exit_task     (i_exit_task),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_total_task    (o_total_task),
        .o_total_ns      (o_total_ns),
        .o_total_present (o_total_present)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int          ID_W     = ptcta_pkg::ID_W;
    localparam int          TIME_W   = ptcta_pkg::TIME_W;
    localparam int unsigned ID_SPACE = ptcta_pkg::ID_SPACE;

    localparam int ITEMS_PER_PHASE = 477;
    localparam int HOLD_AT         = 1080;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   prev;
        logic [ID_W-1:0]   next;
        logic [ID_W-1:0]   gone;
    } t_sched_ev;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] ns;
        logic              present;
    } t_total;

    class t_run_time_book;
        logic [TIME_W-1:0] start_ts [ID_SPACE];
        bit                start_set [ID_SPACE];
        logic [TIME_W-1:0] run_ns [ID_SPACE];
        bit                run_set [ID_SPACE];
        t_total            pending_totals [$];
        int                errors;

        function new();
            foreach (start_set[i]) begin
                start_ts[i]  = '0;
                start_set[i] = 1'b0;
                run_ns[i]    = '0;
                run_set[i]   = 1'b0;
            end
            errors = 0;
        endfunction

        function t_total total_of(logic [ID_W-1:0] id);
            t_total res;
            res.task_id = id;
            res.present = run_set[id];
            res.ns      = run_set[id] ? run_ns[id] : '0;
            return res;
        endfunction

        function void note_event(t_sched_ev ev);
            logic [TIME_W-1:0] delta;
            if (ev.func == ptcta_pkg::FUNC_SWITCH) begin
                if (ev.prev != 0 && start_set[ev.prev]) begin
                    delta = ev.now - start_ts[ev.prev];
                    if (run_set[ev.prev]) begin
                        run_ns[ev.prev] = run_ns[ev.prev] + delta;
                    end else begin
                        run_ns[ev.prev]  = delta;
                        run_set[ev.prev] = 1'b1;
                    end
                end
                if (ev.next != 0) begin
                    start_ts[ev.next]  = ev.now;
                    start_set[ev.next] = 1'b1;
                end
                pending_totals.push_back(total_of(ev.prev));
            end else begin
                pending_totals.push_back(total_of(ev.gone));
                start_set[ev.gone] = 1'b0;
                run_set[ev.gone]   = 1'b0;
                start_ts[ev.gone]  = '0;
                run_ns[ev.gone]    = '0;
            end
        endfunction

        function void check_total(logic [ID_W-1:0] task_id, logic [TIME_W-1:0] ns,
                                  logic present);
            t_total exp_t;
            if (pending_totals.size() == 0) begin
                $error("unexpected result: total_task %0d total_ns %0d total_present %0d",
                       task_id, ns, present);
                errors++;
                return;
            end
            exp_t = pending_totals.pop_front();
            if (task_id !== exp_t.task_id) begin
                $error("total_task mismatch: expected %0d, actual %0d", exp_t.task_id, task_id);
                errors++;
            end
            if (ns !== exp_t.ns) begin
                $error("total_ns mismatch: expected %0d, actual %0d", exp_t.ns, ns);
                errors++;
            end
            if (present !== exp_t.present) begin
                $error("total_present mismatch: expected %0d, actual %0d",
                       exp_t.present, present);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_func;
    logic [TIME_W-1:0] i_time_ns;
    logic [ID_W-1:0]   i_prev_task;
    logic [ID_W-1:0]   i_next_task;
    logic [ID_W-1:0]   i_exit_task;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [ID_W-1:0]   o_total_task;
    logic [TIME_W-1:0] o_total_ns;
    logic              o_total_present;

    t_run_time_book    book = new();
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                events_accepted = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    logic [TIME_W-1:0] clock_ns;
    logic [ID_W-1:0]   running;
    logic [ID_W-1:0]   pool [8];

    per_task_cpu_time_accounting_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_time_ns       (i_time_ns),
        .i_prev_task     (i_prev_task),
        .i_next_task     (i_next_task),
        .i_exit_task     (i_exit_task),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_total_task    (o_total_task),
        .o_total_ns      (o_total_ns),
        .o_total_present (o_total_present)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver, with one long hold-off once the run is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && events_accepted >= HOLD_AT) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            book.check_total(o_total_task, o_total_ns, o_total_present);
        end
    end

    task automatic send_event(input t_sched_ev ev);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_func      <= ev.func;
        i_time_ns   <= ev.now;
        i_prev_task <= ev.prev;
        i_next_task <= ev.next;
        i_exit_task <= ev.gone;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.note_event(ev);
        events_accepted++;
    endtask

    task automatic send_switch(input logic [TIME_W-1:0] now, input logic [ID_W-1:0] prev,
                               input logic [ID_W-1:0] next);
        send_event('{ptcta_pkg::FUNC_SWITCH, now, prev, next, ID_W'($urandom)});
    endtask

    task automatic send_exit(input logic [ID_W-1:0] gone);
        send_event('{ptcta_pkg::FUNC_EXIT, {$urandom, $urandom}, ID_W'($urandom),
                     ID_W'($urandom), gone});
    endtask

    task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
        t_sched_ev ev;
        int        r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (pool[i]) pool[i] = ID_W'($urandom_range(1, ID_SPACE - 1));
        running = pool[0];
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 14) begin
                ev.func = ptcta_pkg::FUNC_EXIT;
                ev.now  = {$urandom, $urandom};
                ev.prev = ID_W'($urandom);
                ev.next = ID_W'($urandom);
                if (r < 2) begin
                    ev.gone = ID_W'($urandom);
                end else if (r < 3) begin
                    ev.gone = '0;
                end else begin
                    ev.gone = pool[$urandom_range(7)];
                end
                if (ev.gone == running) running = '0;
            end else begin
                if ($urandom_range(49) == 0) begin
                    clock_ns = {$urandom, $urandom};
                end else begin
                    clock_ns = clock_ns + $urandom_range(1, 100000);
                end
                ev.func = ptcta_pkg::FUNC_SWITCH;
                ev.now  = clock_ns;
                ev.gone = ID_W'($urandom);
                r = $urandom_range(99);
                if (r < 75) begin
                    ev.prev = running;
                end else if (r < 85) begin
                    ev.prev = '0;
                end else if (r < 95) begin
                    ev.prev = pool[$urandom_range(7)];
                end else begin
                    ev.prev = ID_W'($urandom);
                end
                r = $urandom_range(99);
                if (r < 8) begin
                    ev.next = '0;
                end else if (r < 95) begin
                    ev.next = pool[$urandom_range(7)];
                end else begin
                    ev.next = ID_W'($urandom);
                end
                running = ev.next;
            end
            send_event(ev);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = ptcta_pkg::FUNC_SWITCH;
        i_time_ns   = '0;
        i_prev_task = '0;
        i_next_task = '0;
        i_exit_task = '0;
        i_out_ready = 1'b0;
        clock_ns    = '0;
        running     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 81;
        // idle in and out
        send_switch(64'd0, 12'd0, 12'd0);
        send_switch(64'd100, 12'd0, 12'd5);
        send_switch(64'd350, 12'd5, 12'd7);
        send_switch(64'd1000, 12'd7, 12'd5);
        // same task out and in
        send_switch(64'd1500, 12'd5, 12'd5);
        // outgoing task never started
        send_switch(64'd2000, 12'd9, 12'd0);
        send_switch(64'd2500, 12'd5, 12'd0);
        send_switch(64'd3000, 12'd5, 12'hAAA);
        send_switch(64'd3700, 12'hAAA, 12'h555);
        send_switch('1, 12'h555, 12'hFFF);
        // timestamp wraps between start and stop
        send_switch(64'd5, 12'hFFF, 12'hFFF);
        send_exit(12'hFFF);
        send_exit(12'hFFF);
        send_exit(12'd0);
        send_exit(12'd5);
        send_switch(64'd0, 12'hFFF, 12'd1);
        // accumulated total wraps
        send_switch('1, 12'd1, 12'd1);
        send_switch(64'd1, 12'd1, 12'd0);
        send_switch(64'h8000_0000_0000_0000, 12'd0, 12'd2048);
        send_switch(64'h7FFF_FFFF_FFFF_FFFF, 12'd2048, 12'd0);
        send_exit(12'd1);

        run_random_phase(ITEMS_PER_PHASE, 10, 81);
        clock_ns = 64'hFFFF_FFFF_FFF0_0000;
        run_random_phase(ITEMS_PER_PHASE, 81, 10);
        run_random_phase(ITEMS_PER_PHASE, 0, 0);
        i_in_valid <= 1'b0;

        while (book.pending_totals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.pending_totals.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[per_task_cpu_time_accounting_unit.f]
rtl/ptcta_pkg.sv
rtl/ptcta_ctrl.sv
rtl/ptcta_dpath.sv
rtl/per_task_cpu_time_accounting_unit.sv
tb/tb_top.sv
